### src/gsb_pkg.sv
// Shared types, constants and saturation helpers for the single-bin Goertzel detector.
package gsb_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int XW          = SAMPLE_BITS + 16;  // sample placed at Q.16
  localparam int STW         = 64;                // recursion state width
  localparam int OPA_W       = 64;                // multiplier operand A
  localparam int OPB_W       = 49;                // multiplier operand B
  localparam int PART_W      = 33;                // partial-product operand width
  localparam int PP_W        = 2 * PART_W;        // partial-product width
  localparam int PROD_W      = OPA_W + OPB_W;     // exact product width
  localparam int SUM_W       = 85;                // width of intermediate adds
  localparam int TMP_W       = PROD_W - 30;       // product rounded to Q.16
  localparam int OUT_W       = 34;                // result field width
  localparam int CFG_W       = 48;

  localparam logic [1:0] REG_COEFF  = 2'd0;
  localparam logic [1:0] REG_COSINE = 2'd1;
  localparam logic [1:0] REG_SINE   = 2'd2;
  localparam logic [1:0] REG_SCALE  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC_MUL,
    S_REC_ADD,
    S_COS_MUL,
    S_RE_ADD,
    S_RE_MUL,
    S_RE_SAT,
    S_SIN_MUL,
    S_IM_RND,
    S_IM_MUL,
    S_IM_SAT
  } state_t;

  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  function automatic logic signed [STW-1:0] sat64(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-STW:0] top;
    top = v[SUM_W-1:STW-1];
    if (top == '0 || top == '1) begin
      return v[STW-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(STW-1){1'b0}}};
    end else begin
      return {1'b0, {(STW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] sat34(input logic signed [TMP_W-1:0] v);
    logic [TMP_W-OUT_W:0] top;
    top = v[TMP_W-1:OUT_W-1];
    if (top == '0 || top == '1) begin
      return v[OUT_W-1:0];
    end else if (v[TMP_W-1]) begin
      return {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

### src/gsb_mul.sv
// Shared 64x49 signed multiplier built from four 33x33 partial products.
module gsb_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  gsb_pkg::mul_ctrl_t                     ctrl,
  input  logic signed [gsb_pkg::OPA_W-1:0]       op_a,
  input  logic signed [gsb_pkg::OPB_W-1:0]       op_b,
  output gsb_pkg::mul_stat_t                     stat,
  output logic signed [gsb_pkg::PROD_W-1:0]      prod
);
  import gsb_pkg::*;

  logic                     busy;
  logic [1:0]               cnt;
  logic [1:0]               idx;
  logic                     issue;
  logic signed [PART_W-1:0] part_a;
  logic signed [PART_W-1:0] part_b;
  logic signed [PP_W-1:0]   pp;
  logic                     pp_vld;
  logic [1:0]               pp_idx;
  logic signed [PROD_W-1:0] pp_ext;
  logic signed [PROD_W-1:0] term;
  logic                     done;

  assign issue = ctrl.start || busy;
  assign idx   = ctrl.start ? 2'd0 : cnt;

  // idx bit 0 picks the high half of A, bit 1 the high part of B
  always_comb begin
    part_a = idx[0] ? {op_a[OPA_W-1], op_a[OPA_W-1:32]} : {1'b0, op_a[31:0]};
    part_b = idx[1] ? {{(PART_W - OPB_W + 32){op_b[OPB_W-1]}}, op_b[OPB_W-1:32]}
                    : {1'b0, op_b[31:0]};
  end

  assign pp_ext = pp;

  always_comb begin
    case (pp_idx)
      2'd0:    term = pp_ext;
      2'd3:    term = pp_ext <<< 64;
      default: term = pp_ext <<< 32;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= 2'd0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      pp_vld <= issue;
      done   <= pp_vld && (pp_idx == 2'd3);
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= 2'd1;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pp     <= part_a * part_b;
      pp_idx <= idx;
    end
    if (ctrl.start) begin
      prod <= '0;
    end else if (pp_vld) begin
      prod <= prod + term;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### src/goertzel_single_bin.sv
// Top level of the single-bin Goertzel detector: sequencer, state and result registers.
//
// One shared 33x33 signed multiplier does all the arithmetic; every wide product
// (state times coefficient, intermediate times scale) takes four partial products.
// An ordinary sample drops in_ready after acceptance until its recursion product
// and state update are done, so the next sample waits for the return to idle. A sample
// marked last adds four more products and their rounding and saturation steps:
// real_part and imag_part load together into an output register (later if the
// previous result is still waiting there), and the block then returns to idle to
// take the next sample. The output register holds the result until taken; the block
// already takes the next sample meanwhile.
// Configuration writes take effect at once and should be done while the block
// is idle.
module goertzel_single_bin (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [15:0]                             sample,
  input  logic                                    last,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [gsb_pkg::OUT_W-1:0]        real_part,
  output logic signed [gsb_pkg::OUT_W-1:0]        imag_part,
  input  logic                                    cfg_wen,
  input  logic [1:0]                              cfg_index,
  input  logic [gsb_pkg::CFG_W-1:0]               cfg_data
);
  import gsb_pkg::*;

  state_t state, state_next;

  logic signed [32:0]      coeff_q;
  logic signed [31:0]      cosine_q;
  logic signed [31:0]      sine_q;
  logic [47:0]             scale_q;

  logic signed [STW-1:0]   s1;
  logic signed [STW-1:0]   s2;
  logic signed [STW-1:0]   val;
  logic signed [TMP_W-1:0] tmp;
  logic signed [OUT_W-1:0] real_hold;
  logic [XW-1:0]           x_q;
  logic                    last_q;
  logic                    launch;
  logic                    launch_next;
  logic                    out_free;
  logic                    is_scale_mul;

  mul_ctrl_t                mul_ctrl;
  mul_stat_t                mul_stat;
  logic signed [OPA_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r30;
  logic signed [PROD_W-1:0] prod_r34;

  logic signed [SUM_W-1:0]  s1_ext;
  logic signed [SUM_W-1:0]  s2_ext;
  logic signed [SUM_W-1:0]  tmp_ext;
  logic signed [SUM_W-1:0]  x_ext;
  logic signed [SUM_W-1:0]  rec_sum;
  logic signed [SUM_W-1:0]  re_sum;

  localparam logic signed [PROD_W-1:0] HALF30 = PROD_W'(1) <<< 29;
  localparam logic signed [PROD_W-1:0] HALF34 = PROD_W'(1) <<< 33;

  gsb_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mul_ctrl),
    .op_a (mul_a),
    .op_b (mul_b),
    .stat (mul_stat),
    .prod (prod)
  );

  assign mul_ctrl.start = launch;
  assign out_free       = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_REC_MUL;
      S_REC_MUL: if (mul_stat.done) state_next = S_REC_ADD;
      S_REC_ADD: state_next = last_q ? S_COS_MUL : S_IDLE;
      S_COS_MUL: if (mul_stat.done) state_next = S_RE_ADD;
      S_RE_ADD:  state_next = S_RE_MUL;
      S_RE_MUL:  if (mul_stat.done) state_next = S_RE_SAT;
      S_RE_SAT:  state_next = S_SIN_MUL;
      S_SIN_MUL: if (mul_stat.done) state_next = S_IM_RND;
      S_IM_RND:  state_next = S_IM_MUL;
      S_IM_MUL:  if (mul_stat.done) state_next = S_IM_SAT;
      S_IM_SAT:  if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    in_ready     = 1'b0;
    mul_a        = s1;
    mul_b        = OPB_W'(coeff_q);
    is_scale_mul = 1'b0;
    case (state)
      S_IDLE:    in_ready = 1'b1;
      S_COS_MUL: begin
        mul_a = s2;
        mul_b = OPB_W'(cosine_q);
      end
      S_SIN_MUL: begin
        mul_a = s2;
        mul_b = OPB_W'(sine_q);
      end
      S_RE_MUL, S_IM_MUL: begin
        mul_a        = val;
        mul_b        = {1'b0, scale_q};
        is_scale_mul = 1'b1;
      end
      default: begin
        mul_a = s1;
      end
    endcase
  end

  // start the multiplier on entry to each multiply state
  always_comb begin
    case (state_next)
      S_REC_MUL, S_COS_MUL, S_RE_MUL, S_SIN_MUL, S_IM_MUL:
        launch_next = (state_next != state);
      default:
        launch_next = 1'b0;
    endcase
  end

  assign prod_r30 = prod + HALF30;
  assign prod_r34 = prod + HALF34;

  assign s1_ext  = s1;
  assign s2_ext  = s2;
  assign tmp_ext = tmp;
  assign x_ext   = SUM_W'(x_q);
  assign rec_sum = tmp_ext - s2_ext + x_ext;
  assign re_sum  = s1_ext - tmp_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      out_valid <= 1'b0;
      coeff_q   <= '0;
      cosine_q  <= '0;
      sine_q    <= '0;
      scale_q   <= '0;
      s1        <= '0;
      s2        <= '0;
    end else begin
      state  <= state_next;
      launch <= launch_next;

      if (cfg_wen) begin
        case (cfg_index)
          REG_COEFF:  coeff_q  <= cfg_data[32:0];
          REG_COSINE: cosine_q <= cfg_data[31:0];
          REG_SINE:   sine_q   <= cfg_data[31:0];
          REG_SCALE:  scale_q  <= cfg_data[47:0];
          default:    ;
        endcase
      end

      // load a new result or drop the one just taken
      if (state == S_IM_SAT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_REC_ADD: begin
          s2 <= s1;
          s1 <= sat64(rec_sum);
        end
        S_IM_SAT: begin
          if (out_free) begin
            s1 <= '0;
            s2 <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      x_q    <= {16'(sample[SAMPLE_BITS-1:0]), 16'd0};
      last_q <= last;
    end
    if (mul_stat.done) begin
      if (is_scale_mul) begin
        tmp <= {{(TMP_W - PROD_W + 34){prod_r34[PROD_W-1]}}, prod_r34[PROD_W-1:34]};
      end else begin
        tmp <= prod_r30[PROD_W-1:30];
      end
    end
    case (state)
      S_RE_ADD: val       <= sat64(re_sum);
      S_IM_RND: val       <= sat64(tmp_ext);
      S_RE_SAT: real_hold <= sat34(tmp);
      default:  ;
    endcase
    if (state == S_IM_SAT && out_free) begin
      real_part <= real_hold;
      imag_part <= sat34(tmp);
    end
  end

  // the multiplier is never restarted in the middle of a product
  assert property (@(posedge clk) disable iff (rst) launch |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  // a product only completes while the sequencer waits for one
  assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == S_REC_MUL || state == S_COS_MUL || state == S_RE_MUL ||
                       state == S_SIN_MUL || state == S_IM_MUL))
    else $error("product completed outside a multiply state");

  // an ordinary sample returns to idle right after the state update
  assert property (@(posedge clk) disable iff (rst)
    (state == S_REC_ADD && !last_q) |=> (state == S_IDLE))
    else $error("non-final sample did not return to idle");

  // delivering a result clears the recursion
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IM_SAT && out_free) |=> (s1 == '0 && s2 == '0 && out_valid))
    else $error("recursion not cleared after result");

endmodule
